@@ src/assert_macros.svh @@
// Assertion macros used by the parent candidate table controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge out of reset.
`define PCT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define PCT_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define PCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/pct_pkg.sv @@
// Types, constants and codes shared by the parent candidate table modules.
package pct_pkg;

  localparam int TABLE_ENTRIES = 8;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam int ADDR_W  = 48;
  localparam int TYPE_W  = 2;
  localparam int RANK_W  = 16;
  localparam int SLOTS_W = 8;

  localparam logic [RANK_W-1:0]  RANK_MAX  = '1;
  localparam logic [SLOTS_W-1:0] SLOTS_MAX = '1;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    OUT_UPDATED   = 3'd0,
    OUT_INSERTED  = 3'd1,
    OUT_REPLACED  = 3'd2,
    OUT_IGNORED   = 3'd3,
    OUT_REMOVED   = 3'd4,
    OUT_NOT_FOUND = 3'd5,
    OUT_CLEARED   = 3'd6,
    OUT_QUERY     = 3'd7
  } outcome_t;

  typedef struct packed {
    logic               valid;
    logic [ADDR_W-1:0]  addr;
    logic [TYPE_W-1:0]  addr_type;
    logic [RANK_W-1:0]  rank;
    logic [SLOTS_W-1:0] slot_cnt;
  } entry_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last;
  } dp_status_t;

endpackage

@@ src/pct_in_if.sv @@
// Request channel interface: valid, ready and one table operation.
interface pct_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  operation;
  logic [pct_pkg::ADDR_W-1:0]  peer_addr;
  logic [pct_pkg::TYPE_W-1:0]  peer_addr_type;
  logic [pct_pkg::RANK_W-1:0]  peer_rank;
  logic [pct_pkg::SLOTS_W-1:0] peer_free_slots;

  modport source (output valid, operation, peer_addr, peer_addr_type, peer_rank,
                  peer_free_slots, input ready);
  modport sink (input valid, operation, peer_addr, peer_addr_type, peer_rank,
                peer_free_slots, output ready);
endinterface

@@ src/pct_out_if.sv @@
// Result channel interface: valid, ready and one operation outcome.
interface pct_out_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  outcome;
  logic                        best_found;
  logic [pct_pkg::ADDR_W-1:0]  best_addr;
  logic [pct_pkg::TYPE_W-1:0]  best_addr_type;
  logic [pct_pkg::RANK_W-1:0]  best_rank;
  logic [pct_pkg::SLOTS_W-1:0] best_free_slots;

  modport source (output valid, outcome, best_found, best_addr, best_addr_type, best_rank,
                  best_free_slots, input ready);
  modport sink (input valid, outcome, best_found, best_addr, best_addr_type, best_rank,
                best_free_slots, output ready);
endinterface

@@ src/pct_controller.sv @@
// Sequencing state machine for the parent candidate table: accept, scan, commit.
`include "assert_macros.svh"

module pct_controller (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  pct_pkg::dp_status_t status,
  output pct_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_COMMIT = 3'b100
  } ctl_state_t;

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready   = (state_r == ST_IDLE);
  assign out_valid  = out_valid_r;

  always_comb begin
    cmd.load   = in_valid && (state_r == ST_IDLE);
    cmd.step   = (state_r == ST_SCAN);
    cmd.commit = (state_r == ST_COMMIT) && (!out_valid_r || out_ready);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.load) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.last) state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (cmd.commit) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `PCT_ASSERT_IMPLY(a_commit_slot_free, cmd.commit, !out_valid_r || out_ready, "slot busy")
  `PCT_ASSERT_NEXT(a_accept_starts_scan, in_valid && in_ready, state_r == ST_SCAN, "no scan")
  `PCT_ASSERT_IMPLY(a_result_from_commit, $rose(out_valid_r), $past(cmd.commit), "no commit")
  `PCT_ASSERT(a_no_accept_while_busy, !(in_ready && (state_r != ST_IDLE)), "ready while busy")

endmodule

@@ src/pct_datapath.sv @@
// Candidate table storage, one-entry-per-cycle scan trackers and result registers.
module pct_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pct_pkg::ctrl_cmd_t           cmd,
  output pct_pkg::dp_status_t          status,
  input  logic                         cfg_we,
  input  logic [pct_pkg::RANK_W-1:0]   cfg_wdata,
  input  logic [1:0]                   in_operation,
  input  logic [pct_pkg::ADDR_W-1:0]   in_peer_addr,
  input  logic [pct_pkg::TYPE_W-1:0]   in_peer_addr_type,
  input  logic [pct_pkg::RANK_W-1:0]   in_peer_rank,
  input  logic [pct_pkg::SLOTS_W-1:0]  in_peer_free_slots,
  output logic [2:0]                   out_outcome,
  output logic                         out_best_found,
  output logic [pct_pkg::ADDR_W-1:0]   out_best_addr,
  output logic [pct_pkg::TYPE_W-1:0]   out_best_addr_type,
  output logic [pct_pkg::RANK_W-1:0]   out_best_rank,
  output logic [pct_pkg::SLOTS_W-1:0]  out_best_free_slots
);

  pct_pkg::entry_t                   tbl_r [pct_pkg::TABLE_ENTRIES];
  logic [pct_pkg::RANK_W-1:0]        local_rank_r;

  pct_pkg::op_t                      op_r;
  logic [pct_pkg::ADDR_W-1:0]        pa_r;
  logic [pct_pkg::TYPE_W-1:0]        pt_r;
  logic [pct_pkg::RANK_W-1:0]        pr_r;
  logic [pct_pkg::SLOTS_W-1:0]       ps_r;

  logic [pct_pkg::IDX_W-1:0]         idx_r;
  logic                              match_f_r;
  logic [pct_pkg::IDX_W-1:0]         match_idx_r;
  logic                              free_f_r;
  logic [pct_pkg::IDX_W-1:0]         free_idx_r;
  pct_pkg::entry_t                   trk_r;
  logic [pct_pkg::IDX_W-1:0]         trk_idx_r;

  pct_pkg::outcome_t                 outcome_r;
  pct_pkg::entry_t                   best_r;

  pct_pkg::entry_t                   cur;
  logic                              hit;
  logic                              better;
  logic                              add_ok;
  logic                              replace_ok;
  pct_pkg::outcome_t                 outcome_c;
  logic                              wr_en;
  logic                              rm_en;
  logic [pct_pkg::IDX_W-1:0]         wr_idx;
  pct_pkg::entry_t                   wr_entry;

  assign status.last = (idx_r == pct_pkg::IDX_W'(pct_pkg::TABLE_ENTRIES - 1));

  assign cur = tbl_r[idx_r];

  always_comb begin
    if (op_r == pct_pkg::OP_REMOVE) begin
      hit = (cur.addr == pa_r);
    end else begin
      hit = cur.valid && (cur.addr == pa_r) && (cur.addr_type == pt_r);
    end
    if (op_r == pct_pkg::OP_QUERY) begin
      better = cur.valid && ((cur.rank < trk_r.rank) ||
               ((cur.rank == trk_r.rank) && (cur.slot_cnt < trk_r.slot_cnt)));
    end else begin
      better = cur.valid && ((cur.rank > trk_r.rank) ||
               ((cur.rank == trk_r.rank) && (cur.slot_cnt < trk_r.slot_cnt)));
    end
  end

  always_comb begin
    add_ok     = (local_rank_r == '0) || (pr_r <= local_rank_r);
    replace_ok = trk_r.valid && ((trk_r.rank > pr_r) ||
                 ((trk_r.rank == pr_r) && (trk_r.slot_cnt > ps_r)));
    outcome_c  = pct_pkg::OUT_IGNORED;
    wr_en      = 1'b0;
    rm_en      = 1'b0;
    wr_idx     = match_idx_r;
    wr_entry   = '{valid: 1'b1, addr: pa_r, addr_type: pt_r, rank: pr_r, slot_cnt: ps_r};
    case (op_r)
      pct_pkg::OP_ADD: begin
        if (!add_ok) begin
          outcome_c = pct_pkg::OUT_IGNORED;
        end else if (match_f_r) begin
          outcome_c = pct_pkg::OUT_UPDATED;
          wr_en     = 1'b1;
        end else if (free_f_r) begin
          outcome_c = pct_pkg::OUT_INSERTED;
          wr_en     = 1'b1;
          wr_idx    = free_idx_r;
        end else if (replace_ok) begin
          outcome_c = pct_pkg::OUT_REPLACED;
          wr_en     = 1'b1;
          wr_idx    = trk_idx_r;
        end
      end
      pct_pkg::OP_REMOVE: begin
        outcome_c = match_f_r ? pct_pkg::OUT_REMOVED : pct_pkg::OUT_NOT_FOUND;
        rm_en     = match_f_r;
      end
      pct_pkg::OP_CLEAR: outcome_c = pct_pkg::OUT_CLEARED;
      pct_pkg::OP_QUERY: outcome_c = pct_pkg::OUT_QUERY;
      default: outcome_c = pct_pkg::OUT_IGNORED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_rank_r <= '0;
    end else if (cfg_we) begin
      local_rank_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < pct_pkg::TABLE_ENTRIES; i++) begin
        tbl_r[i] <= '0;
      end
    end else if (cmd.commit) begin
      if (op_r == pct_pkg::OP_CLEAR) begin
        for (int i = 0; i < pct_pkg::TABLE_ENTRIES; i++) begin
          tbl_r[i] <= '0;
        end
      end else if (wr_en) begin
        tbl_r[wr_idx] <= wr_entry;
      end else if (rm_en) begin
        tbl_r[match_idx_r].valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r        <= pct_pkg::op_t'(in_operation);
      pa_r        <= in_peer_addr;
      pt_r        <= in_peer_addr_type;
      pr_r        <= in_peer_rank;
      ps_r        <= in_peer_free_slots;
      idx_r       <= '0;
      match_f_r   <= 1'b0;
      match_idx_r <= '0;
      free_f_r    <= 1'b0;
      free_idx_r  <= '0;
      trk_idx_r   <= '0;
      if (pct_pkg::op_t'(in_operation) == pct_pkg::OP_QUERY) begin
        trk_r <= '{valid: 1'b0, addr: '0, addr_type: '0, rank: pct_pkg::RANK_MAX,
                   slot_cnt: '0};
      end else begin
        trk_r <= '{valid: 1'b0, addr: '0, addr_type: '0, rank: '0,
                   slot_cnt: pct_pkg::SLOTS_MAX};
      end
    end else if (cmd.step) begin
      idx_r <= idx_r + 1'b1;
      if (hit && !match_f_r) begin
        match_f_r   <= 1'b1;
        match_idx_r <= idx_r;
      end
      if (!cur.valid && !free_f_r) begin
        free_f_r   <= 1'b1;
        free_idx_r <= idx_r;
      end
      if (better) begin
        trk_r     <= cur;
        trk_idx_r <= idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      outcome_r <= outcome_c;
      if ((op_r == pct_pkg::OP_QUERY) && trk_r.valid) begin
        best_r <= trk_r;
      end else begin
        best_r <= '0;
      end
    end
  end

  assign out_outcome         = outcome_r;
  assign out_best_found      = best_r.valid;
  assign out_best_addr       = best_r.addr;
  assign out_best_addr_type  = best_r.addr_type;
  assign out_best_rank       = best_r.rank;
  assign out_best_free_slots = best_r.slot_cnt;

endmodule

@@ src/parent_candidate_table_core.sv @@
// Top level of the parent candidate table: controller, datapath and channel wiring.
//
//   channel  dir  handshake        payload
//   in_ch    in   valid/ready      operation, peer address, type, rank, free slots
//   out_ch   out  valid/ready      outcome, best found flag and best entry fields
//   cfg      in   cfg_we           cfg_wdata: local rank
//
// A transaction is accepted in idle, the scan then steps through the table one entry
// per cycle, and the commit step updates the table and the result register.
// A result waits in the output register; the next transaction is taken meanwhile,
// and commit holds only while that register is full and out_ch.ready is low.
// Reset (rst_n low, synchronous) empties the table and sets the local rank to zero.
module parent_candidate_table_core (
  input  logic                       clk,
  input  logic                       rst_n,
  pct_in_if.sink                     in_ch,
  pct_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [pct_pkg::RANK_W-1:0] cfg_wdata
);

  pct_pkg::ctrl_cmd_t  cmd;
  pct_pkg::dp_status_t status;

  pct_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  pct_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_operation        (in_ch.operation),
    .in_peer_addr        (in_ch.peer_addr),
    .in_peer_addr_type   (in_ch.peer_addr_type),
    .in_peer_rank        (in_ch.peer_rank),
    .in_peer_free_slots  (in_ch.peer_free_slots),
    .out_outcome         (out_ch.outcome),
    .out_best_found      (out_ch.best_found),
    .out_best_addr       (out_ch.best_addr),
    .out_best_addr_type  (out_ch.best_addr_type),
    .out_best_rank       (out_ch.best_rank),
    .out_best_free_slots (out_ch.best_free_slots)
  );

endmodule
